[rtl/bezier_pressure_curve_unit_defines.svh]
// ----------------------------------------------------------------------------
// bezier_pressure_curve_unit_defines.svh
// Assertion macros shared by the pressure curve checker.
// ----------------------------------------------------------------------------
`ifndef BEZIER_PRESSURE_CURVE_UNIT_DEFINES_SVH
`define BEZIER_PRESSURE_CURVE_UNIT_DEFINES_SVH

// clocked property, off while reset is held
`define BPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// plain invariant, checked at every edge out of reset
`define BPC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants and register codes of the Bezier pressure curve unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // q1.15 sample format
    localparam int Q15_BITS = 15;
    localparam int PRESS_W  = 16;
    localparam logic [PRESS_W-1:0] PRESS_ONE = 16'd32768;

    // control point register widths
    localparam int CX_W = 16;
    localparam int CY_W = 18;

    // wide scratch width for format conversion
    localparam int WIDE_W = 48;

    // configuration bus
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register reset values, about 1/3 and 2/3
    localparam logic [CX_W-1:0] CTRL1_X_RST = 16'd10923;
    localparam logic [CY_W-1:0] CTRL1_Y_RST = 18'd10923;
    localparam logic [CX_W-1:0] CTRL2_X_RST = 16'd21845;
    localparam logic [CY_W-1:0] CTRL2_Y_RST = 18'd21845;

    // register index, byte address is 4 times this
    typedef enum logic [1:0] {
        REG_CTRL1_X,
        REG_CTRL1_Y,
        REG_CTRL2_X,
        REG_CTRL2_Y
    } bpc_reg_t;

endpackage

[rtl/bpc_curve.sv]
// ----------------------------------------------------------------------------
// bpc_curve
// Three-stage evaluator of one Bezier coordinate at parameter t; returns the
// two weighted control terms and t^3, to be summed by the caller.
// ----------------------------------------------------------------------------
module bpc_curve #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [FRACTION_BITS+3:0] t,
    input  logic signed [FRACTION_BITS+3:0] c1,
    input  logic signed [FRACTION_BITS+3:0] c2,
    output logic                           out_valid,
    output logic signed [FRACTION_BITS+3:0] m1,
    output logic signed [FRACTION_BITS+3:0] m2,
    output logic signed [FRACTION_BITS+3:0] t3
);

    localparam int VW = FRACTION_BITS + 4;
    localparam logic signed [VW-1:0] QONE = VW'(1) << FRACTION_BITS;

    logic signed [VW-1:0]   mt;
    logic signed [2*VW-1:0] p_mm;
    logic signed [2*VW-1:0] p_tt;
    logic signed [2*VW-1:0] p_t3;
    logic signed [2*VW-1:0] p_a1;
    logic signed [2*VW-1:0] p_a2;
    logic signed [2*VW-1:0] p_m1;
    logic signed [2*VW-1:0] p_m2;
    logic signed [VW-1:0]   f_a1;
    logic signed [VW-1:0]   f_a2;
    logic signed [VW-1:0]   a1_next;
    logic signed [VW-1:0]   a2_next;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic signed [VW-1:0] t1_reg;
    logic signed [VW-1:0] mt1_reg;
    logic signed [VW-1:0] mt2_reg;
    logic signed [VW-1:0] t2_reg;
    logic signed [VW-1:0] t3a_reg;
    logic signed [VW-1:0] a1_reg;
    logic signed [VW-1:0] a2_reg;
    logic signed [VW-1:0] m1_reg;
    logic signed [VW-1:0] m2_reg;
    logic signed [VW-1:0] t3b_reg;

    // products, each truncated with floor by the arithmetic shift
    always_comb
    begin
        mt      = QONE - t;
        p_mm    = mt * mt;
        p_tt    = t * t;
        p_t3    = t2_reg * t1_reg;
        p_a1    = mt2_reg * t1_reg;
        p_a2    = mt1_reg * t2_reg;
        f_a1    = VW'(p_a1 >>> FRACTION_BITS);
        f_a2    = VW'(p_a2 >>> FRACTION_BITS);
        a1_next = f_a1 + (f_a1 <<< 1);
        a2_next = f_a2 + (f_a2 <<< 1);
        p_m1    = a1_reg * c1;
        p_m2    = a2_reg * c2;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages: squares, cubic terms, weighted terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg  <= t;
            mt1_reg <= mt;
            mt2_reg <= VW'(p_mm >>> FRACTION_BITS);
            t2_reg  <= VW'(p_tt >>> FRACTION_BITS);
            t3a_reg <= VW'(p_t3 >>> FRACTION_BITS);
            a1_reg  <= a1_next;
            a2_reg  <= a2_next;
            m1_reg  <= VW'(p_m1 >>> FRACTION_BITS);
            m2_reg  <= VW'(p_m2 >>> FRACTION_BITS);
            t3b_reg <= t3a_reg;
        end
    end

    assign out_valid = v3_reg;
    assign m1        = m1_reg;
    assign m2        = m2_reg;
    assign t3        = t3b_reg;

endmodule

[rtl/bpc_cell.sv]
// ----------------------------------------------------------------------------
// bpc_cell
// One bisection step: takes the interval, evaluates X at its midpoint and
// hands the narrowed interval and the midpoint to the next cell.
// ----------------------------------------------------------------------------
module bpc_cell #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [FRACTION_BITS+3:0] in_lo,
    input  logic signed [FRACTION_BITS+3:0] in_hi,
    input  logic signed [FRACTION_BITS+3:0] in_p,
    input  logic signed [FRACTION_BITS+3:0] c1x,
    input  logic signed [FRACTION_BITS+3:0] c2x,
    output logic                           out_valid,
    output logic signed [FRACTION_BITS+3:0] out_lo,
    output logic signed [FRACTION_BITS+3:0] out_hi,
    output logic signed [FRACTION_BITS+3:0] out_t,
    output logic signed [FRACTION_BITS+3:0] out_p
);

    localparam int VW    = FRACTION_BITS + 4;
    localparam int SW    = VW + 2;
    localparam int DEPTH = 3;

    logic signed [VW-1:0] t_mid;
    logic                 cv_valid;
    logic signed [VW-1:0] cm1;
    logic signed [VW-1:0] cm2;
    logic signed [VW-1:0] ct3;
    logic signed [SW-1:0] x_sum;
    logic                 below;

    logic signed [VW-1:0] lo_d_reg [DEPTH];
    logic signed [VW-1:0] hi_d_reg [DEPTH];
    logic signed [VW-1:0] p_d_reg  [DEPTH];
    logic signed [VW-1:0] t_d_reg  [DEPTH];
    logic                 valid_reg;
    logic signed [VW-1:0] lo_reg;
    logic signed [VW-1:0] hi_reg;
    logic signed [VW-1:0] t_reg;
    logic signed [VW-1:0] p_reg;

    // midpoint of the incoming interval
    assign t_mid = VW'((in_lo + in_hi) >>> 1);

    bpc_curve #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_xcurve (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .t         (t_mid),
        .c1        (c1x),
        .c2        (c2x),
        .out_valid (cv_valid),
        .m1        (cm1),
        .m2        (cm2),
        .t3        (ct3)
    );

    // interval and sample ride alongside the evaluator
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_d_reg[0] <= in_lo;
            hi_d_reg[0] <= in_hi;
            p_d_reg[0]  <= in_p;
            t_d_reg[0]  <= t_mid;
            for (int i = 1; i < DEPTH; i++)
            begin
                lo_d_reg[i] <= lo_d_reg[i-1];
                hi_d_reg[i] <= hi_d_reg[i-1];
                p_d_reg[i]  <= p_d_reg[i-1];
                t_d_reg[i]  <= t_d_reg[i-1];
            end
        end
    end

    // curve x against the sample decides which bound moves
    always_comb
    begin
        x_sum = SW'(cm1) + SW'(cm2) + SW'(ct3);
        below = x_sum < SW'(p_d_reg[DEPTH-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= cv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg <= below ? t_d_reg[DEPTH-1] : lo_d_reg[DEPTH-1];
            hi_reg <= below ? hi_d_reg[DEPTH-1] : t_d_reg[DEPTH-1];
            t_reg  <= t_d_reg[DEPTH-1];
            p_reg  <= p_d_reg[DEPTH-1];
        end
    end

    assign out_valid = valid_reg;
    assign out_lo    = lo_reg;
    assign out_hi    = hi_reg;
    assign out_t     = t_reg;
    assign out_p     = p_reg;

endmodule

[rtl/bezier_pressure_curve_unit.sv]
// ----------------------------------------------------------------------------
// bezier_pressure_curve_unit
// Shapes pen pressure samples through a cubic Bezier curve with endpoints
// (0,0) and (1,1): a row of bisection cells finds t, then Y is taken at t.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------
//   s_*      | in  | raw_pressure, q1.15 unsigned
//   m_*      | out | shaped_pressure, q1.15 unsigned, 0..1
//   p*       | in  | control point registers at 0x0, 0x4, 0x8, 0xc
//
// One sample per clock while the chain is not halted; each cell has four
// stages (squares, cubic terms, weighted terms, compare), followed by the
// three-stage Y evaluator and the output register.
// Reset loads the default control points and empties the chain.
// The chain halts only when the result register is full, not taken, and the
// tail stage holds a result; otherwise input beats keep flowing.
// ----------------------------------------------------------------------------
module bezier_pressure_curve_unit #(
    parameter int ITERATIONS    = 10,
    parameter int FRACTION_BITS = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // raw_pressure [15:0]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpc_pkg::PRESS_W-1:0]  s_tdata,
    // shaped_pressure [15:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bpc_pkg::PRESS_W-1:0]  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::APB_AW-1:0]   paddr,
    input  logic [bpc_pkg::APB_DW-1:0]   pwdata,
    output logic [bpc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import bpc_pkg::*;

    localparam int VW     = FRACTION_BITS + 4;
    localparam int SW     = VW + 2;
    localparam int SH_UP  = (FRACTION_BITS >= Q15_BITS) ? FRACTION_BITS - Q15_BITS : 0;
    localparam int SH_DN  = (FRACTION_BITS >= Q15_BITS) ? 0 : Q15_BITS - FRACTION_BITS;
    localparam logic signed [VW-1:0] QONE   = VW'(1) << FRACTION_BITS;
    localparam logic signed [SW-1:0] QONE_S = SW'(1) << FRACTION_BITS;

    bpc_reg_t                 reg_idx;
    logic                     cfg_wr;
    logic [CX_W-1:0]          c1x_reg;
    logic signed [CY_W-1:0]   c1y_reg;
    logic [CX_W-1:0]          c2x_reg;
    logic signed [CY_W-1:0]   c2y_reg;

    logic signed [VW-1:0]     c1x_s;
    logic signed [VW-1:0]     c1y_s;
    logic signed [VW-1:0]     c2x_s;
    logic signed [VW-1:0]     c2y_s;
    logic signed [VW-1:0]     p_s;

    logic                     adv;
    logic                     out_load;
    logic                     ch_valid [0:ITERATIONS];
    logic signed [VW-1:0]     ch_lo    [0:ITERATIONS];
    logic signed [VW-1:0]     ch_hi    [0:ITERATIONS];
    logic signed [VW-1:0]     ch_p     [0:ITERATIONS];
    logic signed [VW-1:0]     ch_t     [1:ITERATIONS];

    logic                     yv;
    logic signed [VW-1:0]     ym1;
    logic signed [VW-1:0]     ym2;
    logic signed [VW-1:0]     yt3;
    logic signed [SW-1:0]     y_sum;
    logic signed [SW-1:0]     y_cl;
    logic [PRESS_W-1:0]       y_q;

    logic                     out_valid_reg;
    logic [PRESS_W-1:0]       shaped_reg;

    // configuration port
    assign reg_idx = bpc_reg_t'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1x_reg <= CTRL1_X_RST;
            c1y_reg <= CTRL1_Y_RST;
            c2x_reg <= CTRL2_X_RST;
            c2y_reg <= CTRL2_Y_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CTRL1_X: c1x_reg <= pwdata[CX_W-1:0];
                REG_CTRL1_Y: c1y_reg <= pwdata[CY_W-1:0];
                REG_CTRL2_X: c2x_reg <= pwdata[CX_W-1:0];
                REG_CTRL2_Y: c2y_reg <= pwdata[CY_W-1:0];
                default:     c1x_reg <= c1x_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CTRL1_X: prdata = APB_DW'(c1x_reg);
            REG_CTRL1_Y: prdata = APB_DW'($unsigned(c1y_reg));
            REG_CTRL2_X: prdata = APB_DW'(c2x_reg);
            REG_CTRL2_Y: prdata = APB_DW'($unsigned(c2y_reg));
            default:     prdata = '0;
        endcase
    end

    // q1.15 to the internal format: shift up, or floor shift down
    always_comb
    begin
        c1x_s = VW'((WIDE_W'($signed({1'b0, c1x_reg})) <<< SH_UP) >>> SH_DN);
        c2x_s = VW'((WIDE_W'($signed({1'b0, c2x_reg})) <<< SH_UP) >>> SH_DN);
        c1y_s = VW'((WIDE_W'(c1y_reg) <<< SH_UP) >>> SH_DN);
        c2y_s = VW'((WIDE_W'(c2y_reg) <<< SH_UP) >>> SH_DN);
        p_s   = VW'((WIDE_W'($signed({1'b0, s_tdata})) <<< SH_UP) >>> SH_DN);
    end

    // chain feed: full interval [0, 1]
    assign s_tready    = adv;
    assign ch_valid[0] = s_tvalid && adv;
    assign ch_lo[0]    = '0;
    assign ch_hi[0]    = QONE;
    assign ch_p[0]     = p_s;

    // row of bisection cells
    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_cell
        bpc_cell #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (ch_valid[g]),
            .in_lo     (ch_lo[g]),
            .in_hi     (ch_hi[g]),
            .in_p      (ch_p[g]),
            .c1x       (c1x_s),
            .c2x       (c2x_s),
            .out_valid (ch_valid[g+1]),
            .out_lo    (ch_lo[g+1]),
            .out_hi    (ch_hi[g+1]),
            .out_t     (ch_t[g+1]),
            .out_p     (ch_p[g+1])
        );
    end

    // y at the last midpoint
    bpc_curve #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ycurve (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ch_valid[ITERATIONS]),
        .t         (ch_t[ITERATIONS]),
        .c1        (c1y_s),
        .c2        (c2y_s),
        .out_valid (yv),
        .m1        (ym1),
        .m2        (ym2),
        .t3        (yt3)
    );

    // sum, clamp to 0..1, back to q1.15
    always_comb
    begin
        y_sum = SW'(ym1) + SW'(ym2) + SW'(yt3);
        if (y_sum < 0)
        begin
            y_cl = '0;
        end
        else if (y_sum > QONE_S)
        begin
            y_cl = QONE_S;
        end
        else
        begin
            y_cl = y_sum;
        end
        y_q = PRESS_W'((WIDE_W'(y_cl) >>> SH_UP) <<< SH_DN);
    end

    // output register; chain moves unless a held result blocks the tail
    assign out_load = !out_valid_reg || m_tready;
    assign adv      = out_load || !yv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= yv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && yv)
        begin
            shaped_reg <= y_q;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = shaped_reg;

endmodule

[rtl/bpc_checker.sv]
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the pressure curve unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "bezier_pressure_curve_unit_defines.svh"

module bpc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bpc_pkg::PRESS_W-1:0]  m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [bpc_pkg::APB_AW-1:0]   paddr,
    input logic [bpc_pkg::APB_DW-1:0]   pwdata,
    input logic [bpc_pkg::APB_DW-1:0]   prdata,
    input logic                         pready
);

    import bpc_pkg::*;

    logic              out_stall;
    logic              c1x_wr;
    logic              c1x_rd;
    logic [CX_W-1:0]   wr_c1x;
    logic [CX_W-1:0]   rd_c1x;

    // stalled result beat and bus phases on the first control point register
    assign out_stall = m_tvalid && !m_tready;
    assign c1x_wr    = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CTRL1_X);
    assign c1x_rd    = psel && !pwrite && (paddr[APB_AW-1:2] == REG_CTRL1_X);
    assign wr_c1x    = pwdata[CX_W-1:0];
    assign rd_c1x    = prdata[CX_W-1:0];

    // a held result beat stays put
    `BPC_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata), "held beat changed")

    // clamp keeps results within 0..1
    `BPC_ASSERT(a_out_range, m_tvalid |-> (m_tdata <= PRESS_ONE), "shaped pressure above 1.0")

    // an empty result register never blocks the input
    `BPC_ASSERT(a_in_open, !m_tvalid |-> s_tready, "input stalled with no result pending")

    // first control point x reads back what was written
    `BPC_ASSERT(a_cfg_readback, c1x_wr |=> !c1x_rd || rd_c1x == $past(wr_c1x), "ctrl1_x readback")

    `BPC_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind bezier_pressure_curve_unit bpc_checker u_bpc_checker (.*);
